@@ src/chunk_header_stream_parser_defines.svh @@
// Assertion macros for the chunk header stream parser.
// Each macro expects signals named clock and reset in the calling scope.
`ifndef CHUNK_HEADER_STREAM_PARSER_DEFINES_SVH
`define CHUNK_HEADER_STREAM_PARSER_DEFINES_SVH

`ifndef SYNTHESIS

// prop must hold at every edge outside reset
`define CHP_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("chp assertion failed");

// expr must never be true outside reset
`define CHP_ASSERT_NEVER(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error("chp forbidden condition seen");

`else

`define CHP_ASSERT(lbl, prop)
`define CHP_ASSERT_NEVER(lbl, expr)

`endif

`endif

@@ src/chp_pkg.sv @@
package chp_pkg;

   // longest varint lead: 1111110x takes five continuation bytes
   localparam logic [2:0] MAX_CONTINUATIONS = 3'd5;

   typedef enum logic [2:0] {
      PH_ID_LEAD  = 3'd0,
      PH_ID_CONT  = 3'd1,
      PH_FLAGS    = 3'd2,
      PH_LEN_LEAD = 3'd3,
      PH_LEN_CONT = 3'd4,
      PH_CONTENT  = 3'd5,
      PH_HALT     = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      KIND_HEADER  = 2'd0,
      KIND_CONTENT = 2'd1,
      KIND_ERROR   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ERR_STRAY_CONT   = 2'd0,
      ERR_INVALID_LEAD = 2'd1,
      ERR_MISSING_CONT = 2'd2
   } err_type;

   typedef struct packed {
      phase_type   phase;
      logic [30:0] acc;
      logic [2:0]  cont_left;
      logic [30:0] held_id;
      logic [7:0]  held_flag;
      logic [30:0] remaining;
   } state_type;

   typedef struct packed {
      kind_type    kind;
      logic [30:0] chunk_id;
      logic [2:0]  chunk_type;
      logic [4:0]  chunk_flags;
      logic [30:0] content_length;
      logic [7:0]  data_byte;
      logic        last_content;
      err_type     error_code;
   } result_type;

endpackage

@@ src/chp_step.sv @@
module chp_step
   import chp_pkg::*;
(
   input  state_type  cur_i,
   input  logic [7:0] byte_i,
   output state_type  nxt_o,
   output result_type res_o,
   output logic       res_valid_o
);

   logic [2:0]  lead_n;
   logic [7:0]  lead_keep;
   logic [30:0] acc_shift;
   logic [2:0]  left_dec;
   logic [30:0] rem_dec;

   // leading-ones decode of a multi-byte lead; zero count means 0xFE/0xFF
   always_comb begin
      priority if (byte_i[7:5] == 3'b110) begin
         lead_n = 3'd1; lead_keep = 8'h1F;
      end else if (byte_i[7:4] == 4'b1110) begin
         lead_n = 3'd2; lead_keep = 8'h0F;
      end else if (byte_i[7:3] == 5'b11110) begin
         lead_n = 3'd3; lead_keep = 8'h07;
      end else if (byte_i[7:2] == 6'b111110) begin
         lead_n = 3'd4; lead_keep = 8'h03;
      end else if (byte_i[7:1] == 7'b1111110) begin
         lead_n = 3'd5; lead_keep = 8'h01;
      end else begin
         lead_n = 3'd0; lead_keep = 8'h00;
      end
   end

   assign acc_shift = {cur_i.acc[24:0], byte_i[5:0]};
   assign left_dec  = cur_i.cont_left - 3'd1;
   assign rem_dec   = cur_i.remaining - 31'd1;

   always_comb begin
      logic        is_len;
      logic        done;
      logic [30:0] done_val;
      logic        hdr;
      logic [30:0] hdr_len;
      logic [7:0]  hdr_flag;
      logic        err;
      err_type     err_code;

      nxt_o       = cur_i;
      res_o       = '0;
      res_valid_o = 1'b0;
      is_len      = 1'b0;
      done        = 1'b0;
      done_val    = '0;
      hdr         = 1'b0;
      hdr_len     = '0;
      hdr_flag    = cur_i.held_flag;
      err         = 1'b0;
      err_code    = ERR_STRAY_CONT;

      unique case (cur_i.phase)
         PH_ID_LEAD, PH_LEN_LEAD: begin
            is_len = (cur_i.phase == PH_LEN_LEAD);
            if (!byte_i[7]) begin
               done     = 1'b1;
               done_val = {23'd0, byte_i};
            end else if (!byte_i[6]) begin
               err      = 1'b1;
               err_code = ERR_STRAY_CONT;
            end else if (lead_n == 3'd0 || lead_n > MAX_CONTINUATIONS) begin
               err      = 1'b1;
               err_code = ERR_INVALID_LEAD;
            end else begin
               nxt_o.acc       = {23'd0, byte_i & lead_keep};
               nxt_o.cont_left = lead_n;
               nxt_o.phase     = is_len ? PH_LEN_CONT : PH_ID_CONT;
            end
         end
         PH_ID_CONT, PH_LEN_CONT: begin
            is_len = (cur_i.phase == PH_LEN_CONT);
            if (byte_i[7:6] != 2'b10) begin
               err      = 1'b1;
               err_code = ERR_MISSING_CONT;
            end else begin
               nxt_o.acc       = acc_shift;
               nxt_o.cont_left = left_dec;
               if (left_dec == 3'd0) begin
                  done     = 1'b1;
                  done_val = acc_shift;
               end
            end
         end
         PH_FLAGS: begin
            nxt_o.held_flag = byte_i;
            hdr_flag        = byte_i;
            if (byte_i[5]) begin
               // short chunk: no length varint
               hdr     = 1'b1;
               hdr_len = 31'd1;
            end else begin
               nxt_o.phase = PH_LEN_LEAD;
            end
         end
         PH_CONTENT: begin
            res_valid_o     = 1'b1;
            res_o.kind      = KIND_CONTENT;
            res_o.data_byte = byte_i;
            nxt_o.remaining = rem_dec;
            if (rem_dec == 31'd0) begin
               res_o.last_content = 1'b1;
               nxt_o.phase        = PH_ID_LEAD;
            end
         end
         PH_HALT: begin
         end
         default: begin
         end
      endcase

      if (done) begin
         if (!is_len) begin
            nxt_o.held_id = done_val;
            nxt_o.phase   = PH_FLAGS;
         end else begin
            hdr     = 1'b1;
            hdr_len = done_val;
         end
      end

      if (hdr) begin
         res_valid_o          = 1'b1;
         res_o.kind           = KIND_HEADER;
         res_o.chunk_id       = cur_i.held_id;
         res_o.chunk_type     = hdr_flag[2:0];
         res_o.chunk_flags    = hdr_flag[7:3];
         res_o.content_length = hdr_len;
         nxt_o.remaining      = hdr_len;
         nxt_o.phase          = (hdr_len == 31'd0) ? PH_ID_LEAD : PH_CONTENT;
      end

      if (err) begin
         res_valid_o      = 1'b1;
         res_o            = '0;
         res_o.kind       = KIND_ERROR;
         res_o.error_code = err_code;
         nxt_o.phase      = PH_HALT;
      end
   end

endmodule

@@ src/chunk_header_stream_parser.sv @@
// Chunk header stream parser.
// req channel: one raw stream byte per transaction (req_stream_byte).
// rsp channel: zero or one result transaction per input byte: a chunk
//   header (id, type, flags, length), a content byte (with last marker),
//   or an error. Bytes that complete no header (id bytes, flag byte of a
//   long chunk, varint lead/continuation bytes) give no result.
// A byte accepted into the input register is parsed from there once the
//   result slot is free, and its result is written to the output register.
// Throughput: one byte per cycle while rsp_ready stays high; set by the
//   single parse step between the input register and the result register.
// Stall: while rsp_ready is low and a result is held, the input register
//   still accepts one byte; further bytes wait on req_ready. req_ready
//   follows rsp_ready combinationally.
// Reset: synchronous, active high; empties both registers and returns
//   the parser to expecting a chunk id.
// After an error the block keeps accepting bytes and drops them silently
//   until the next reset.
`include "chunk_header_stream_parser_defines.svh"

module chunk_header_stream_parser
   import chp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_stream_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [30:0] rsp_chunk_id,
   output logic [2:0]  rsp_chunk_type,
   output logic [4:0]  rsp_chunk_flags,
   output logic [30:0] rsp_content_length,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_last_content,
   output logic [1:0]  rsp_error_code
);

   // input register
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;

   // parser state
   state_type  state_ff;
   state_type  state_in;

   // result register
   logic       rsp_valid_ff;
   result_type rsp_ff;

   result_type step_res;
   logic       step_valid;
   logic       advance;

   // short names for the checks at the end
   logic       err_held;
   logic       in_cont_phase;
   logic       content_empty;

   chp_step u_step (
      .cur_i       (state_ff),
      .byte_i      (in_byte_ff),
      .nxt_o       (state_in),
      .res_o       (step_res),
      .res_valid_o (step_valid)
   );

   // parse the held byte once the result slot is free (or draining now)
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_stream_byte;
      end
   end

   // only the phase needs a reset; every other field is written before use
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase <= PH_ID_LEAD;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= step_valid;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && step_valid) begin
         rsp_ff <= step_res;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_ff.kind;
   assign rsp_chunk_id       = rsp_ff.chunk_id;
   assign rsp_chunk_type     = rsp_ff.chunk_type;
   assign rsp_chunk_flags    = rsp_ff.chunk_flags;
   assign rsp_content_length = rsp_ff.content_length;
   assign rsp_data_byte      = rsp_ff.data_byte;
   assign rsp_last_content   = rsp_ff.last_content;
   assign rsp_error_code     = rsp_ff.error_code;

   assign err_held      = rsp_valid_ff && (rsp_ff.kind == KIND_ERROR);
   assign in_cont_phase = (state_ff.phase == PH_ID_CONT) || (state_ff.phase == PH_LEN_CONT);
   assign content_empty = (state_ff.phase == PH_CONTENT) && (state_ff.remaining == 31'd0);

   // halt is terminal until reset
   `CHP_ASSERT(a_halt_sticky, (state_ff.phase == PH_HALT) |=> (state_ff.phase == PH_HALT))

   // an error result in the output register means the parser has halted
   `CHP_ASSERT(a_err_halts, err_held |-> (state_ff.phase == PH_HALT))

   // content phase always has bytes left to pass through
   `CHP_ASSERT_NEVER(a_content_nonzero, content_empty)

   // continuation phases always expect at least one more byte
   `CHP_ASSERT_NEVER(a_cont_nonzero, in_cont_phase && (state_ff.cont_left == 3'd0))

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
   import chp_pkg::*;

   localparam int unsigned LIMIT_CYCLES = 400000;
   localparam int unsigned DRAIN_CYCLES = 20;
   localparam int unsigned HOLD_CYCLES  = 200;

   // DUT connections: every input has a known value from time zero
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_stream_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_kind;
   logic [30:0] rsp_chunk_id;
   logic [2:0]  rsp_chunk_type;
   logic [4:0]  rsp_chunk_flags;
   logic [30:0] rsp_content_length;
   logic [7:0]  rsp_data_byte;
   logic        rsp_last_content;
   logic [1:0]  rsp_error_code;

   chunk_header_stream_parser uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_stream_byte    (req_stream_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_chunk_id       (rsp_chunk_id),
      .rsp_chunk_type     (rsp_chunk_type),
      .rsp_chunk_flags    (rsp_chunk_flags),
      .rsp_content_length (rsp_content_length),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_last_content   (rsp_last_content),
      .rsp_error_code     (rsp_error_code)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // raw bytes waiting to be offered, and records the parser must produce
   logic [7:0]  stream_bytes [$];
   result_type  chunk_records [$];
   int unsigned mismatches = 0;
   int unsigned bytes_accepted = 0;
   int unsigned cycle_count = 0;

   // ------------------------------------------------------------------
   // Parser model: own copy of the parse state, advanced once per
   // accepted byte. Returns 1 when the byte produces a result record.
   // ------------------------------------------------------------------
   phase_type   p_phase = PH_ID_LEAD;
   logic [30:0] p_acc = '0;
   logic [2:0]  p_left = '0;
   logic [30:0] p_id = '0;
   logic [7:0]  p_flag = '0;
   logic [30:0] p_remaining = '0;

   function automatic bit parse_byte(input logic [7:0] b, output result_type rec);
      logic        is_len;
      logic        done;
      logic [30:0] value;
      logic [2:0]  n;
      logic [7:0]  keep;
      rec = '0;
      done = 1'b0;
      value = '0;
      n = '0;
      keep = '0;
      is_len = (p_phase == PH_LEN_LEAD) || (p_phase == PH_LEN_CONT);
      case (p_phase)
         PH_ID_LEAD, PH_LEN_LEAD: begin
            if (b < 8'h80) begin
               value = 31'(b);
               done = 1'b1;
            end else if (b < 8'hC0) begin
               rec.kind = KIND_ERROR;
               rec.error_code = ERR_STRAY_CONT;
               p_phase = PH_HALT;
               return 1'b1;
            end else if (b >= 8'hFE) begin
               rec.kind = KIND_ERROR;
               rec.error_code = ERR_INVALID_LEAD;
               p_phase = PH_HALT;
               return 1'b1;
            end else begin
               casez (b)
                  8'b110?????: begin n = 3'd1; keep = 8'h1F; end
                  8'b1110????: begin n = 3'd2; keep = 8'h0F; end
                  8'b11110???: begin n = 3'd3; keep = 8'h07; end
                  8'b111110??: begin n = 3'd4; keep = 8'h03; end
                  default: begin n = 3'd5; keep = 8'h01; end
               endcase
               if (n > MAX_CONTINUATIONS) begin
                  rec.kind = KIND_ERROR;
                  rec.error_code = ERR_INVALID_LEAD;
                  p_phase = PH_HALT;
                  return 1'b1;
               end
               p_acc = 31'(b & keep);
               p_left = n;
               p_phase = is_len ? PH_LEN_CONT : PH_ID_CONT;
            end
         end
         PH_ID_CONT, PH_LEN_CONT: begin
            if (b[7:6] != 2'b10) begin
               rec.kind = KIND_ERROR;
               rec.error_code = ERR_MISSING_CONT;
               p_phase = PH_HALT;
               return 1'b1;
            end
            // six bits per continuation, MSB first; top bits fall off
            p_acc = {p_acc[24:0], b[5:0]};
            p_left = p_left - 3'd1;
            if (p_left == 3'd0) begin
               value = p_acc;
               done = 1'b1;
            end
         end
         PH_FLAGS: begin
            p_flag = b;
            if (b[5]) begin
               // short chunk: no length field, one content byte
               value = 31'd1;
               done = 1'b1;
               is_len = 1'b1;
            end else begin
               p_phase = PH_LEN_LEAD;
            end
         end
         PH_CONTENT: begin
            rec.kind = KIND_CONTENT;
            rec.data_byte = b;
            p_remaining = p_remaining - 31'd1;
            if (p_remaining == '0) begin
               rec.last_content = 1'b1;
               p_phase = PH_ID_LEAD;
            end
            return 1'b1;
         end
         default: return 1'b0;   // halted: bytes are dropped
      endcase
      if (!done)
         return 1'b0;
      if (!is_len) begin
         p_id = value;
         p_phase = PH_FLAGS;
         return 1'b0;
      end
      rec.kind = KIND_HEADER;
      rec.chunk_id = p_id;
      rec.chunk_type = p_flag[2:0];
      rec.chunk_flags = p_flag[7:3];
      rec.content_length = value;
      p_remaining = value;
      p_phase = (value == '0) ? PH_ID_LEAD : PH_CONTENT;
      return 1'b1;
   endfunction

   // ------------------------------------------------------------------
   // Stream builders
   // ------------------------------------------------------------------

   // value encoded with a chosen number of continuation bytes (0 = single
   // byte); overlong encodings are legal and get exercised here
   task automatic add_varint(input logic [30:0] value, input int unsigned conts);
      logic [7:0]  prefix;
      logic [7:0]  keep;
      int unsigned i;
      if (conts == 0) begin
         stream_bytes.push_back({1'b0, value[6:0]});
      end else begin
         prefix = 8'hFF << (7 - conts);
         keep = 8'hFF >> (conts + 2);
         stream_bytes.push_back(prefix | (8'(value >> (6 * conts)) & keep));
         for (i = conts; i > 0; i--)
            stream_bytes.push_back(8'h80 | (8'(value >> (6 * (i - 1))) & 8'h3F));
      end
   endtask

   task automatic add_header(input logic [30:0] id, input int unsigned id_conts,
                             input logic [7:0] flag, input logic [30:0] len,
                             input int unsigned len_conts);
      add_varint(id, id_conts);
      stream_bytes.push_back(flag);
      if (!flag[5])
         add_varint(len, len_conts);
   endtask

   task automatic add_random_chunk();
      int unsigned id_conts;
      int unsigned len_conts;
      int unsigned bits;
      int unsigned len;
      int unsigned k;
      logic [30:0] id;
      logic [7:0]  flag;
      id_conts = $urandom_range(0, 5);
      bits = (id_conts == 0) ? 7 : 6 + 5 * id_conts;
      id = 31'($urandom) & 31'((64'd1 << bits) - 1);
      flag = 8'($urandom);
      flag[5] = ($urandom_range(0, 2) == 0);
      k = $urandom_range(0, 19);
      if (k < 3)
         len = 0;
      else if (k < 17)
         len = $urandom_range(1, 6);
      else
         len = $urandom_range(7, 40);
      len_conts = $urandom_range(0, 1) ? 0 : $urandom_range(1, 5);
      add_header(id, id_conts, flag, 31'(len), len_conts);
      if (flag[5])
         len = 1;
      repeat (len) stream_bytes.push_back(8'($urandom));
   endtask

   function automatic int unsigned idle_length();
      if ($urandom_range(0, 99) < 80)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // ------------------------------------------------------------------
   // Driver: one raw byte per transaction; the model runs on acceptance
   // ------------------------------------------------------------------
   int unsigned send_idle = 0;
   int unsigned send_quiet = 0;
   result_type  sent_rec;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            bytes_accepted++;
            if (parse_byte(req_stream_byte, sent_rec))
               chunk_records.push_back(sent_rec);
         end
         if (send_quiet > 0)
            send_quiet--;
         else if ($urandom_range(0, 299) == 0)
            send_quiet = $urandom_range(100, 300);
         // payload may only change once the current byte is taken
         if (!(req_valid && !req_ready)) begin
            if (send_idle > 0) begin
               send_idle--;
               req_valid <= 1'b0;
            end else if (stream_bytes.size() > 0 &&
                         (send_quiet > 0 || $urandom_range(0, 99) >= 25)) begin
               req_valid <= 1'b1;
               req_stream_byte <= stream_bytes[0];
               stream_bytes.delete(0);
            end else begin
               if (stream_bytes.size() > 0)
                  send_idle = idle_length();
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Long receiver hold-off, twice per run, so the parser backs up and
   // drops req_ready while bytes keep coming
   // ------------------------------------------------------------------
   logic        hold_off = 1'b0;
   int unsigned hold_left = 0;
   int unsigned holds_done = 0;

   always @(posedge clock) begin
      if (reset) begin
         hold_off <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         hold_off <= (hold_left != 0);
      end else if (holds_done < 2 && bytes_accepted >= 300 + 450 * holds_done) begin
         holds_done++;
         hold_left = HOLD_CYCLES;
         hold_off <= 1'b1;
      end else begin
         hold_off <= 1'b0;
      end
   end

   // ------------------------------------------------------------------
   // Monitor: compare each result transaction with the oldest record
   // ------------------------------------------------------------------
   function automatic void check_field(input string field_name,
                                       input longint unsigned want,
                                       input longint unsigned got);
      if (want != got) begin
         $error("%s: expected 0x%0h, got 0x%0h", field_name, want, got);
         mismatches++;
      end
   endfunction

   int unsigned recv_stall = 0;
   int unsigned recv_quiet = 0;
   logic        ready_next;
   result_type  want_rec;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (chunk_records.size() == 0) begin
               $error("unexpected result transaction: kind %0d", rsp_kind);
               mismatches++;
            end else begin
               want_rec = chunk_records[0];
               chunk_records.delete(0);
               check_field("kind", want_rec.kind, rsp_kind);
               check_field("chunk_id", want_rec.chunk_id, rsp_chunk_id);
               check_field("chunk_type", want_rec.chunk_type, rsp_chunk_type);
               check_field("chunk_flags", want_rec.chunk_flags, rsp_chunk_flags);
               check_field("content_length", want_rec.content_length,
                           rsp_content_length);
               check_field("data_byte", want_rec.data_byte, rsp_data_byte);
               check_field("last_content", want_rec.last_content, rsp_last_content);
               check_field("error_code", want_rec.error_code, rsp_error_code);
            end
         end
         if (recv_quiet > 0)
            recv_quiet--;
         else if ($urandom_range(0, 299) == 0)
            recv_quiet = $urandom_range(100, 300);
         if (recv_stall > 0) begin
            recv_stall--;
            ready_next = 1'b0;
         end else if (recv_quiet == 0 && $urandom_range(0, 99) < 30) begin
            recv_stall = idle_length();
            ready_next = 1'b0;
         end else begin
            ready_next = 1'b1;
         end
         rsp_ready <= ready_next && !hold_off;
      end
   end

   // hard stop if the pipeline wedges
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus and end of run
   // ------------------------------------------------------------------
   initial begin
      int unsigned ending;
      int unsigned n;
      int unsigned good;
      logic [7:0]  bad;

      // directed: short chunk with id 0
      add_header(31'd0, 0, 8'h20, 31'd0, 0);
      stream_bytes.push_back(8'h00);
      // largest single-byte id, zero length, no content follows
      add_header(31'h7F, 0, 8'hD7, 31'd0, 0);
      // widest id over five continuations, all-ones flag byte (short)
      add_header(31'h7FFF_FFFF, 5, 8'hFF, 31'd0, 0);
      stream_bytes.push_back(8'hFF);
      // one-continuation id, type 7, two-byte content
      add_header(31'd1, 1, 8'h07, 31'd2, 1);
      stream_bytes.push_back(8'h55);
      stream_bytes.push_back(8'hAA);
      // array flag set, overlong length over three continuations
      add_header(31'h3F, 0, 8'h48, 31'd1, 3);
      stream_bytes.push_back(8'h80);

      // random well-formed chunks
      while (stream_bytes.size() < 1100)
         add_random_chunk();

      // one malformed tail: the parser halts for good after it
      ending = $urandom_range(0, 5);
      if (ending >= 3)
         add_header(31'($urandom_range(0, 127)), 0, 8'($urandom) & 8'hDF, 31'd0, 0);
      if (ending >= 3)
         stream_bytes.pop_back();   // drop the length byte, keep id and flags
      case (ending % 3)
         0: stream_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
         1: stream_bytes.push_back(8'hFE + 8'($urandom_range(0, 1)));
         default: begin
            n = $urandom_range(1, 5);
            good = $urandom_range(0, n - 1);
            stream_bytes.push_back((8'hFF << (7 - n)) | (8'($urandom) & (8'hFF >> (n + 2))));
            repeat (good) stream_bytes.push_back(8'h80 | (8'($urandom) & 8'h3F));
            do bad = 8'($urandom); while (bad[7:6] == 2'b10);
            stream_bytes.push_back(bad);
         end
      endcase
      // bytes after the error must vanish silently
      repeat (10) stream_bytes.push_back(8'($urandom));

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // sample away from the active edge so queue updates have settled
      do @(negedge clock); while (stream_bytes.size() != 0 || req_valid);
      do @(negedge clock); while (chunk_records.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatches == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
